@@ rtl/hac_pkg.sv @@
package hac_pkg;

  // Largest count that a bin can hold.
  localparam logic [30:0] BinMax = 31'h7FFF_FFFF;

  // Number of quotient bits produced for a normalize division.
  localparam int unsigned LongBits = 31;

  typedef enum logic [1:0] {
    MODE_HIT   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_NORM  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_LEFT  = 2'd0,
    REG_RIGHT = 2'd1,
    REG_BINS  = 2'd2,
    REG_NONE  = 2'd3
  } reg_e;

  typedef struct packed {
    logic start;
    logic long_mode;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

@@ rtl/histogram_accumulator_core.sv @@
// A hit or query in range goes through the divider, which finds the bin one quotient bit a
// cycle; a sample out of range skips the divider. A clear writes one bin a cycle.
// A normalize over the bins in use is a scan, then a 31-step division per bin, or with a
// negative scale a zeroing of each bin; it ends after the scan if every bin is empty.
// Throughput: one request at a time, the next taken once the result register has been loaded.
// Reset: a clearing pass zeroes the bins; no request is accepted meanwhile.
module histogram_accumulator_core import hac_pkg::*; #(
  parameter int unsigned NUM_BINS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request stream.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]   s_axis_tuser_i,   // [1:0] mode
  // Result stream.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] bin_index, [38:8] bin_count, [46:39] peak_index,
  // [110:47] hit_sum, [142:111] hit_total, [143] zero
  output logic [143:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o,   // [1:0] status
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IDXW = $clog2(NUM_BINS);
  localparam int unsigned CNTW = $clog2(NUM_BINS + 1);

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOC,
    ST_CHK,
    ST_DSTART,
    ST_DIV,
    ST_RD,
    ST_UPD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SCAN_END,
    ST_NRM_RD,
    ST_NRM_MUL,
    ST_NRM_DSTART,
    ST_NRM_DIV,
    ST_CLR,
    ST_DONE
  } state_e;

  // Configuration registers.
  logic signed [31:0] left_q;
  logic signed [31:0] right_q;
  logic [8:0]         bins_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= 32'sd0;
      right_q <= 32'sd65536;
      bins_q  <= 9'd256;
    end else if (psel && penable && pwrite) begin
      case (reg_e'(paddr[3:2]))
        REG_LEFT:  left_q  <= pwdata;
        REG_RIGHT: right_q <= pwdata;
        REG_BINS:  bins_q  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_LEFT:  prdata = left_q;
      REG_RIGHT: prdata = right_q;
      REG_BINS:  prdata = {23'd0, bins_q};
      default:   prdata = 32'd0;
    endcase
  end

  // Bins in use, clamped to the range one to NUM_BINS.
  logic [CNTW-1:0] cnt_used;

  always_comb begin
    if (bins_q == 9'd0) begin
      cnt_used = CNTW'(1);
    end else if (32'(bins_q) > 32'(NUM_BINS)) begin
      cnt_used = CNTW'(NUM_BINS);
    end else begin
      cnt_used = CNTW'(bins_q);
    end
  end

  state_e             state_q;
  logic [1:0]         mode_q;
  logic signed [31:0] value_q;
  logic signed [32:0] diff_q;
  logic signed [32:0] span_q;
  logic [63:0]        prod_q;
  logic [IDXW-1:0]    ptr_q;
  logic [30:0]        max_q;
  logic [IDXW-1:0]    pidx_q;
  logic [IDXW-1:0]    peak_q;
  logic signed [63:0] sum_q;
  logic [31:0]        total_q;
  logic [1:0]         res_status_q;
  logic [IDXW-1:0]    res_idx_q;
  logic [30:0]        res_cnt_q;
  logic               out_valid_q;
  logic [143:0]       out_data_q;
  logic [1:0]         out_user_q;

  // Bin memory, one address shared by reads and writes.
  logic        ram_we;
  logic [30:0] ram_wdata;
  logic [30:0] ram_rdata;

  hac_ram #(
    .DEPTH (NUM_BINS),
    .AW    (IDXW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ptr_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Shared divider: it finds the bin of a sample and rescales every bin in use.
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic [30:0] quotient;

  assign div_req.start     = (state_q == ST_DSTART) || (state_q == ST_NRM_DSTART);
  assign div_req.long_mode = (state_q == ST_NRM_DSTART);

  hac_div #(
    .SHORT_BITS (IDXW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (prod_q),
    .divisor_i  (div_req.long_mode ? {2'b00, max_q} : span_q),
    .rsp_o      (div_rsp),
    .quotient_o (quotient)
  );

  // Shared multiplier: sample offset times bins in use, or bin times scale.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    if (state_q == ST_NRM_MUL) begin
      mul_a = {1'b0, ram_rdata};
      mul_b = value_q;
    end else begin
      mul_a = diff_q[31:0];
      mul_b = 32'(cnt_used);
    end
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Incremented bin, saturating at the largest count.
  logic [30:0] bin_inc;
  assign bin_inc = (ram_rdata != BinMax) ? ram_rdata + 31'd1 : ram_rdata;

  // Saturating running sum.
  logic [64:0]        sum_wide;
  logic signed [63:0] sum_next;

  assign sum_wide = {sum_q[63], sum_q} + {{33{value_q[31]}}, value_q};

  always_comb begin
    if (sum_wide[64] != sum_wide[63]) begin
      sum_next = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_next = sum_wide[63:0];
    end
  end

  logic last_bin;
  logic last_all;

  assign last_bin = (CNTW'(ptr_q) == cnt_used - CNTW'(1));
  assign last_all = (ptr_q == IDXW'(NUM_BINS - 1));

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 31'd0;
    case (state_q)
      ST_INIT, ST_CLR: ram_we = 1'b1;
      ST_UPD: begin
        ram_we    = (mode_e'(mode_q) == MODE_HIT);
        ram_wdata = bin_inc;
      end
      ST_NRM_MUL: ram_we = value_q[31];
      ST_NRM_DIV: begin
        ram_we    = div_rsp.done;
        ram_wdata = quotient;
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      ptr_q        <= '0;
      mode_q       <= MODE_HIT;
      value_q      <= '0;
      diff_q       <= '0;
      span_q       <= '0;
      prod_q       <= '0;
      max_q        <= '0;
      pidx_q       <= '0;
      peak_q       <= '0;
      sum_q        <= '0;
      total_q      <= '0;
      res_status_q <= STATUS_OK;
      res_idx_q    <= '0;
      res_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_user_q   <= STATUS_OK;
    end else begin
      // In the final state the result register is reloaded instead.
      if (out_valid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          if (last_all) begin
            ptr_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            ptr_q <= ptr_q + IDXW'(1);
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            mode_q       <= s_axis_tuser_i;
            value_q      <= s_axis_tdata_i;
            res_status_q <= STATUS_OK;
            res_idx_q    <= '0;
            res_cnt_q    <= '0;
            ptr_q        <= '0;
            case (mode_e'(s_axis_tuser_i))
              MODE_HIT, MODE_QUERY: state_q <= ST_LOC;
              MODE_NORM:            state_q <= ST_SCAN_RD;
              MODE_CLEAR:           state_q <= ST_CLR;
              default:              state_q <= ST_IDLE;
            endcase
          end
        end
        ST_LOC: begin
          diff_q  <= 33'(value_q) - 33'(left_q);
          span_q  <= 33'(right_q) - 33'(left_q);
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          // In range exactly when the sample lies in [left, right).
          if (span_q[32] || (span_q == 33'sd0) || diff_q[32] || (diff_q >= span_q)) begin
            res_status_q <= STATUS_RANGE;
            state_q      <= ST_DONE;
          end else begin
            prod_q  <= mul_p;
            state_q <= ST_DSTART;
          end
        end
        ST_DSTART: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) begin
            ptr_q     <= quotient[IDXW-1:0];
            res_idx_q <= quotient[IDXW-1:0];
            state_q   <= ST_RD;
          end
        end
        ST_RD: state_q <= ST_UPD;
        ST_UPD: begin
          if (mode_e'(mode_q) == MODE_HIT) begin
            res_cnt_q <= bin_inc;
            sum_q     <= sum_next;
            if (total_q != 32'hFFFF_FFFF) begin
              total_q <= total_q + 32'd1;
            end
          end else begin
            res_cnt_q <= ram_rdata;
          end
          state_q <= ST_DONE;
        end
        ST_SCAN_RD: state_q <= ST_SCAN_CMP;
        ST_SCAN_CMP: begin
          // Highest index holding the largest count, unless bin zero holds it.
          if (ptr_q == '0) begin
            max_q  <= ram_rdata;
            pidx_q <= '0;
          end else if ((ram_rdata > max_q) || ((ram_rdata == max_q) && (pidx_q != '0))) begin
            max_q  <= ram_rdata;
            pidx_q <= ptr_q;
          end
          if (last_bin) begin
            state_q <= ST_SCAN_END;
          end else begin
            ptr_q   <= ptr_q + IDXW'(1);
            state_q <= ST_SCAN_RD;
          end
        end
        ST_SCAN_END: begin
          ptr_q <= '0;
          if (max_q == 31'd0) begin
            peak_q       <= '0;
            res_status_q <= STATUS_EMPTY;
            state_q      <= ST_DONE;
          end else begin
            peak_q    <= pidx_q;
            res_idx_q <= pidx_q;
            state_q   <= ST_NRM_RD;
          end
        end
        ST_NRM_RD: state_q <= ST_NRM_MUL;
        ST_NRM_MUL: begin
          if (value_q[31]) begin
            // A negative scale empties every bin in use.
            if (ptr_q == peak_q) begin
              res_cnt_q <= 31'd0;
            end
            if (last_bin) begin
              state_q <= ST_DONE;
            end else begin
              ptr_q   <= ptr_q + IDXW'(1);
              state_q <= ST_NRM_RD;
            end
          end else begin
            prod_q  <= mul_p;
            state_q <= ST_NRM_DSTART;
          end
        end
        ST_NRM_DSTART: state_q <= ST_NRM_DIV;
        ST_NRM_DIV: begin
          if (div_rsp.done) begin
            if (ptr_q == peak_q) begin
              res_cnt_q <= quotient;
            end
            if (last_bin) begin
              state_q <= ST_DONE;
            end else begin
              ptr_q   <= ptr_q + IDXW'(1);
              state_q <= ST_NRM_RD;
            end
          end
        end
        ST_CLR: begin
          if (last_all) begin
            sum_q   <= '0;
            total_q <= '0;
            state_q <= ST_DONE;
          end else begin
            ptr_q <= ptr_q + IDXW'(1);
          end
        end
        ST_DONE: begin
          // The result register takes the new result once the old one is gone.
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_user_q  <= res_status_q;
            out_data_q  <= {1'b0, total_q, sum_q, 8'(peak_q), res_cnt_q, 8'(res_idx_q)};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/hac_div.sv @@
module hac_div import hac_pkg::*; #(
  parameter int unsigned SHORT_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  output div_rsp_t    rsp_o,
  output logic [30:0] quotient_o
);

  // Restoring division, one quotient bit a cycle. The caller guarantees that
  // the quotient fits in the number of bits requested.
  logic [63:0] rem_q;
  logic [63:0] dsh_q;
  logic [30:0] quo_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [64:0] trial;

  assign trial = {1'b0, rem_q} - {1'b0, dsh_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsh_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        rem_q  <= dividend_i;
        quo_q  <= '0;
        if (req_i.long_mode) begin
          dsh_q <= 64'(divisor_i) << (LongBits - 1);
          cnt_q <= 5'(LongBits - 1);
        end else begin
          dsh_q <= 64'(divisor_i) << (SHORT_BITS - 1);
          cnt_q <= 5'(SHORT_BITS - 1);
        end
      end else if (busy_q) begin
        if (!trial[64]) begin
          rem_q <= trial[63:0];
          quo_q <= {quo_q[29:0], 1'b1};
        end else begin
          quo_q <= {quo_q[29:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.done  = done_q;
  assign quotient_o  = quo_q;

endmodule

@@ rtl/hac_ram.sv @@
module hac_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [30:0]   wdata_i,
  output logic [30:0]   rdata_o
);

  logic [30:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

@@ dv/histogram_accumulator_core_test.sv @@
`timescale 1ns / 100ps

module histogram_accumulator_core_test;
  import hac_pkg::*;

  // The pacing allows for the clearing pass after reset and for a few dozen
  // normalize requests at full width.
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned NumBins = 256;
  localparam int unsigned RandPerPhase = 120;

  typedef struct packed {
    status_e            status;
    logic [7:0]         bin_index;
    logic [30:0]        bin_count;
    logic [7:0]         peak_index;
    logic signed [63:0] hit_sum;
    logic [31:0]        hit_total;
  } hist_result_t;

  // One line of the directed table. Where typed is set, the expected result
  // is written out in full and the predictor only follows the state.
  typedef struct {
    mode_e        mode;
    logic [31:0]  value;
    bit           typed;
    hist_result_t answer;
  } directed_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [31:0]  s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [143:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  histogram_accumulator_core #(.NUM_BINS(NumBins)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: the bins, totals and register copies of the block.
  logic [31:0]        model_bins [NumBins];
  logic signed [63:0] model_sum;
  logic [31:0]        model_total;
  logic [7:0]         model_peak;
  logic signed [31:0] cfg_left;
  logic signed [31:0] cfg_right;
  logic [8:0]         cfg_bins;

  hist_result_t awaited_results[$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_stall_pct = 0;

  // Bins in use, with zero acting as one and anything beyond the store
  // acting as the whole store.
  function automatic int unsigned bins_active();
    if (cfg_bins == 0) return 1;
    if (cfg_bins > NumBins) return NumBins;
    return cfg_bins;
  endfunction

  function automatic bit find_bin(logic signed [31:0] sample, output int unsigned bin);
    longint span, offset;
    span = longint'(cfg_right) - longint'(cfg_left);
    offset = longint'(sample) - longint'(cfg_left);
    bin = 0;
    if (span <= 0 || offset < 0) return 1'b0;
    bin = int'((offset * longint'(bins_active())) / span);
    if (offset * longint'(bins_active()) / span >= bins_active()) begin
      bin = 0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the predicted histogram by one request and returns its result.
  function automatic hist_result_t predict_histogram(mode_e mode, logic signed [31:0] sample);
    hist_result_t r;
    int unsigned  bin, peak, used;
    logic [31:0]  top;
    longint       sum_max, sum_min;
    sum_max = 64'sh7FFF_FFFF_FFFF_FFFF;
    sum_min = -sum_max - 1;
    r = '0;
    r.status = STATUS_OK;
    case (mode)
      MODE_HIT, MODE_QUERY: begin
        if (!find_bin(sample, bin)) begin
          r.status = STATUS_RANGE;
        end else begin
          if (mode == MODE_HIT) begin
            if (model_bins[bin] < 32'(BinMax)) model_bins[bin]++;
            if (sample > 0 && model_sum > sum_max - sample) model_sum = sum_max;
            else if (sample < 0 && model_sum < sum_min - sample) model_sum = sum_min;
            else model_sum = model_sum + sample;
            if (model_total != '1) model_total++;
          end
          r.bin_index = 8'(bin);
          r.bin_count = 31'(model_bins[bin]);
        end
      end
      MODE_NORM: begin
        used = bins_active();
        peak = 0;
        top = model_bins[0];
        // Walking downwards with a strict compare keeps the highest index
        // among equal maxima, and bin 0 unless something beats it.
        for (int i = int'(used) - 1; i >= 0; i--) begin
          if (model_bins[i] > top) begin
            peak = i;
            top = model_bins[i];
          end
        end
        if (top == 0) begin
          r.status = STATUS_EMPTY;
          model_peak = '0;
        end else begin
          model_peak = 8'(peak);
          for (int i = 0; i < int'(used); i++) begin
            if (sample < 0) model_bins[i] = '0;
            else model_bins[i] = 32'((64'(model_bins[i]) * 64'(sample)) / 64'(top));
            if (model_bins[i] > 32'(BinMax)) model_bins[i] = 32'(BinMax);
          end
          r.bin_index = 8'(peak);
          r.bin_count = 31'(model_bins[peak]);
        end
      end
      default: begin
        foreach (model_bins[i]) model_bins[i] = '0;
        model_sum = '0;
        model_total = '0;
      end
    endcase
    r.peak_index = model_peak;
    r.hit_sum = model_sum;
    r.hit_total = model_total;
    return r;
  endfunction

  // Register write in a setup phase and an access phase; the predictor copy follows at
  // once, which is safe since writes happen only while nothing is in flight.
  task automatic write_register(reg_e index, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(index) << 2;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_LEFT:  cfg_left = data;
      REG_RIGHT: cfg_right = data;
      REG_BINS:  cfg_bins = data[8:0];
      default: ;
    endcase
  endtask

  // Presents one request from a falling edge, waits for it to be taken and
  // records what the block should answer. Returns at a falling edge.
  task automatic send_request(mode_e mode, logic [31:0] value, bit typed,
                              hist_result_t answer);
    hist_result_t predicted;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= value;
    s_axis_tuser_i <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = predict_histogram(mode, value);
    awaited_results.push_back(typed ? answer : predicted);
    @(negedge clk_i);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Holds the request side back until every result has arrived.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic hist_result_t typed_result(status_e status, int unsigned bin,
                                                int unsigned count, longint sum,
                                                int unsigned total);
    hist_result_t r;
    r.status = status;
    r.bin_index = 8'(bin);
    r.bin_count = 31'(count);
    r.peak_index = '0;
    r.hit_sum = sum;
    r.hit_total = 32'(total);
    return r;
  endfunction

  // A sample drawn so that most requests land inside the configured range.
  function automatic logic [31:0] pick_sample();
    longint span;
    int unsigned pick;
    span = longint'(cfg_right) - longint'(cfg_left);
    pick = $urandom_range(99);
    if (span <= 0 || pick < 15) return $urandom;
    if (pick < 19) return cfg_left;
    if (pick < 23) return 32'(longint'(cfg_right) - 1);
    if (pick < 25) return cfg_right;
    if (pick < 27) return 32'(longint'(cfg_left) - 1);
    return 32'(longint'(cfg_left) + longint'({$urandom, $urandom} % 64'(span)));
  endfunction

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    hist_result_t want;
    hist_result_t seen;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      seen.status = status_e'(m_axis_tuser_o);
      seen.bin_index = m_axis_tdata_o[7:0];
      seen.bin_count = m_axis_tdata_o[38:8];
      seen.peak_index = m_axis_tdata_o[46:39];
      seen.hit_sum = m_axis_tdata_o[110:47];
      seen.hit_total = m_axis_tdata_o[142:111];
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (seen.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, seen.status);
          fail_count++;
        end
        if (seen.bin_index != want.bin_index) begin
          $error("bin_index: expected %0d, got %0d", want.bin_index, seen.bin_index);
          fail_count++;
        end
        if (seen.bin_count != want.bin_count) begin
          $error("bin_count: expected %0d, got %0d", want.bin_count, seen.bin_count);
          fail_count++;
        end
        if (seen.peak_index != want.peak_index) begin
          $error("peak_index: expected %0d, got %0d", want.peak_index, seen.peak_index);
          fail_count++;
        end
        if (seen.hit_sum != want.hit_sum) begin
          $error("hit_sum: expected %0d, got %0d", want.hit_sum, seen.hit_sum);
          fail_count++;
        end
        if (seen.hit_total != want.hit_total) begin
          $error("hit_total: expected %0d, got %0d", want.hit_total, seen.hit_total);
          fail_count++;
        end
      end
    end
  end

  // The result side stalls at random, at the rate of the current phase.
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    logic signed [31:0] phase_left [7];
    logic signed [31:0] phase_right [7];
    logic [8:0]         phase_bins [7];
    hist_result_t       none;
    int unsigned        pick;
    mode_e              mode;
    logic [31:0]        value;

    none = '0;
    cfg_left = 0;
    cfg_right = 65536;
    cfg_bins = 9'd256;
    foreach (model_bins[i]) model_bins[i] = '0;
    model_sum = '0;
    model_total = '0;
    model_peak = '0;

    // Ranges: the reset one, the widest possible, a single bin, an odd bin
    // count, the narrowest span at the top, an inverted range, and a bin
    // count beyond the store that must act as the whole store.
    phase_left  = '{0, 32'sh8000_0000, -65536, 1000, 32'sh7FFF_FFFE, 100, -5000};
    phase_right = '{65536, 32'sh7FFF_FFFF, 65536, 1000 + 37 * 977, 32'sh7FFF_FFFF, -100, 300000};
    phase_bins  = '{9'd256, 9'd256, 9'd1, 9'd37, 9'd0, 9'd5, 9'd511};

    // Under the reset range a sample's bin is simply its value shifted down
    // by eight, so the first rows can be written out by hand.
    rows = '{
      '{MODE_QUERY, 32'd0, 1'b1, typed_result(STATUS_OK, 0, 0, 0, 0)},
      '{MODE_NORM, 32'd5, 1'b1, typed_result(STATUS_EMPTY, 0, 0, 0, 0)},
      '{MODE_QUERY, 32'hFFFF_FFFF, 1'b1, typed_result(STATUS_RANGE, 0, 0, 0, 0)},
      '{MODE_HIT, 32'd0, 1'b1, typed_result(STATUS_OK, 0, 1, 0, 1)},
      '{MODE_HIT, 32'd65535, 1'b1, typed_result(STATUS_OK, 255, 1, 65535, 2)},
      '{MODE_HIT, 32'd65536, 1'b1, typed_result(STATUS_RANGE, 0, 0, 65535, 2)},
      '{MODE_HIT, 32'h8000_0000, 1'b1, typed_result(STATUS_RANGE, 0, 0, 65535, 2)},
      '{MODE_HIT, 32'h7FFF_FFFF, 1'b1, typed_result(STATUS_RANGE, 0, 0, 65535, 2)},
      '{MODE_HIT, 32'd300, 1'b0, none},
      '{MODE_HIT, 32'd511, 1'b0, none},
      '{MODE_QUERY, 32'd256, 1'b0, none},
      '{MODE_NORM, 32'd1000, 1'b0, none},
      '{MODE_NORM, 32'hFFFF_FFFF, 1'b0, none},
      '{MODE_NORM, 32'd7, 1'b0, none},
      '{MODE_HIT, 32'd100, 1'b0, none},
      '{MODE_HIT, 32'h7FFF, 1'b0, none},
      '{MODE_HIT, 32'h7FFF, 1'b0, none},
      '{MODE_NORM, 32'h7FFF_FFFF, 1'b0, none},
      '{MODE_HIT, 32'h7FFF, 1'b0, none},
      '{MODE_QUERY, 32'h7F00, 1'b0, none},
      '{MODE_NORM, 32'd0, 1'b0, none},
      '{MODE_CLEAR, 32'hFFFF_FFFF, 1'b0, none},
      '{MODE_QUERY, 32'h7FFF, 1'b0, none}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 7; phase++) begin
      // Registers change only once the block has answered everything.
      drain_results();
      write_register(REG_LEFT, phase_left[phase]);
      write_register(REG_RIGHT, phase_right[phase]);
      write_register(REG_BINS, 32'(phase_bins[phase]));
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
        default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
      endcase
      @(negedge clk_i);
      if (phase == 0) begin
        foreach (rows[i]) send_request(rows[i].mode, rows[i].value, rows[i].typed,
                                       rows[i].answer);
      end
      for (int n = 0; n < RandPerPhase; n++) begin
        // Mostly hits with queries between them; a normalize walks every
        // bin in use, so it stays rare.
        pick = $urandom_range(999);
        if (pick < 700) mode = MODE_HIT;
        else if (pick < 960) mode = MODE_QUERY;
        else if (pick < 980) mode = MODE_NORM;
        else mode = MODE_CLEAR;
        if (mode == MODE_NORM) value = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000);
        else if (mode == MODE_CLEAR) value = $urandom;
        else value = pick_sample();
        send_request(mode, value, 1'b0, none);
      end
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hac_pkg.sv
rtl/hac_div.sv
rtl/hac_ram.sv
rtl/histogram_accumulator_core.sv
dv/histogram_accumulator_core_test.sv
